[hw/rtl/lpcs_pkg.sv]
// Shared types and constants for the LED pattern command sequencer.
// No dependencies; used by every module of the block.
package lpcs_pkg;

  localparam logic [2:0] KIND_SET_PIXEL = 3'd0;
  localparam logic [2:0] KIND_FILL      = 3'd1;
  localparam logic [2:0] KIND_SHOW      = 3'd2;
  localparam logic [2:0] KIND_DELAY     = 3'd3;
  localparam logic [2:0] KIND_FADE      = 3'd4;

  localparam logic [2:0] ACT_SET_PIXEL  = 3'd0;
  localparam logic [2:0] ACT_FILL       = 3'd1;
  localparam logic [2:0] ACT_SHOW       = 3'd2;
  localparam logic [2:0] ACT_DELAY      = 3'd3;
  localparam logic [2:0] ACT_FADE_FRAME = 3'd4;

  localparam int FADE_FRAMES = 50;
  localparam int STEP_W      = 6;
  localparam int CMDQ_DEPTH  = 4;

  typedef struct packed {
    logic [2:0]  kind;
    logic        first_step;
    logic [15:0] arg_a;
    logic [7:0]  arg_b;
    logic [7:0]  arg_c;
    logic [15:0] arg_param;
    logic [3:0]  wait_ms;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] delay_ms;
    logic        last;
  } res_t;

  typedef struct packed {
    logic              fading;
    logic [STEP_W-1:0] step;
  } bk_stat_t;

endpackage

[hw/rtl/lpcs_front.sv]
// Front end: takes input items, drops those with no effect, works out the
// fade frame wait. Depends on lpcs_pkg.
module lpcs_front (
  input  logic               in_push_ok,
  input  logic [2:0]         in_kind,
  input  logic               in_first_step,
  input  logic [15:0]        in_arg_a,
  input  logic [7:0]         in_arg_b,
  input  logic [7:0]         in_arg_c,
  input  logic [15:0]        in_arg_param,
  output logic               q_wr,
  output lpcs_pkg::cmd_t     q_wdata
);

  logic [5:0] nib_sum;
  logic [9:0] q5_prod;
  logic [3:0] q5;
  logic [2:0] r5;
  logic       keep;

  // 16 == 1 mod 5, so the nibble sum keeps the residue
  assign nib_sum = 6'(in_arg_a[3:0]) + 6'(in_arg_a[7:4])
                 + 6'(in_arg_a[11:8]) + 6'(in_arg_a[15:12]);
  assign q5_prod = 10'(nib_sum) * 10'd13;
  assign q5      = q5_prod[9:6];
  assign r5      = 3'(nib_sum - 6'(q5) * 6'd5);

  assign keep = (in_kind <= lpcs_pkg::KIND_FADE) || in_first_step;
  assign q_wr = in_push_ok && keep;

  always_comb begin
    q_wdata.kind       = in_kind;
    q_wdata.first_step = in_first_step;
    q_wdata.arg_a      = in_arg_a;
    q_wdata.arg_b      = in_arg_b;
    q_wdata.arg_c      = in_arg_c;
    q_wdata.arg_param  = in_arg_param;
    q_wdata.wait_ms    = {r5 + 3'd1, 1'b0};
  end

endmodule

[hw/rtl/lpcs_cmdq.sv]
// Command queue between front end and back end.
// Depends on lpcs_pkg for the item type.
module lpcs_cmdq #(
  parameter int DEPTH = lpcs_pkg::CMDQ_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  lpcs_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output lpcs_pkg::cmd_t rd_data,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lpcs_pkg::cmd_t   ent_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      ent_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[hw/rtl/lpcs_back.sv]
// Back end: runs queued commands, holds the current color, steps fades one
// frame per cycle while pop keeps up into res_r. Depends on lpcs_pkg.
module lpcs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  lpcs_pkg::cmd_t     q_data,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output lpcs_pkg::res_t     res,
  output lpcs_pkg::bk_stat_t stat
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FADE = 2'b10
  } state_t;

  localparam int SW = lpcs_pkg::STEP_W;

  state_t             state_r, state_nxt;
  logic [SW-1:0]      step_r, step_nxt;
  logic [2:0][7:0]    cur_r, cur_nxt;
  logic [2:0][7:0]    tgt_r, tgt_nxt;
  logic [2:0][2:0]    dq_r, dq_nxt;
  logic [2:0][5:0]    dr_r, dr_nxt;
  logic [2:0][7:0]    qa_r, qa_nxt;
  logic [2:0][5:0]    rem_r, rem_nxt;
  logic [2:0]         neg_r, neg_nxt;
  logic [3:0]         wait_r, wait_nxt;
  logic               vld_r, vld_nxt;
  lpcs_pkg::res_t     res_r, res_nxt;

  logic [2:0][7:0]    cur_eff, tgt_in, mag, frame_col, qv;
  logic [2:0][8:0]    delta;
  logic [2:0][13:0]   dq_prod;
  logic [2:0][2:0]    dq_in;
  logic [2:0][5:0]    dr_in, rem_new;
  logic [2:0][6:0]    rem_sum;
  logic [2:0]         wrap;
  logic               can_emit, last_frame;

  assign can_emit   = !vld_r || pop;
  assign last_frame = (step_r == SW'(lpcs_pkg::FADE_FRAMES - 1));

  // fade setup: |delta| = 50*dq + dr, then frame s adds dq and dr with carry
  always_comb begin
    tgt_in = {q_data.arg_param[7:0], q_data.arg_c, q_data.arg_b};
    for (int i = 0; i < 3; i++) begin
      cur_eff[i]   = q_data.first_step ? 8'd0 : cur_r[i];
      delta[i]     = {1'b0, tgt_in[i]} - {1'b0, cur_eff[i]};
      mag[i]       = delta[i][8] ? 8'(-delta[i]) : delta[i][7:0];
      dq_prod[i]   = 14'(mag[i]) * 14'd41;
      dq_in[i]     = dq_prod[i][13:11];
      dr_in[i]     = 6'(mag[i] - 8'(dq_in[i]) * 8'd50);
      rem_sum[i]   = 7'(rem_r[i]) + 7'(dr_r[i]);
      wrap[i]      = (rem_sum[i] >= 7'(lpcs_pkg::FADE_FRAMES));
      rem_new[i]   = wrap[i] ? 6'(rem_sum[i] - 7'(lpcs_pkg::FADE_FRAMES))
                             : rem_sum[i][5:0];
      qv[i]        = qa_r[i] + 8'(dq_r[i]) + 8'(wrap[i]);
      frame_col[i] = neg_r[i] ? cur_r[i] - qv[i] : cur_r[i] + qv[i];
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cur_nxt   = cur_r;
    tgt_nxt   = tgt_r;
    dq_nxt    = dq_r;
    dr_nxt    = dr_r;
    qa_nxt    = qa_r;
    rem_nxt   = rem_r;
    neg_nxt   = neg_r;
    wait_nxt  = wait_r;
    vld_nxt   = vld_r && !pop;
    res_nxt   = res_r;
    q_pop     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          priority if (q_data.kind == lpcs_pkg::KIND_FADE) begin
            q_pop     = 1'b1;
            cur_nxt   = cur_eff;
            tgt_nxt   = tgt_in;
            dq_nxt    = dq_in;
            dr_nxt    = dr_in;
            qa_nxt    = '0;
            rem_nxt   = '0;
            for (int i = 0; i < 3; i++) begin
              neg_nxt[i] = delta[i][8];
            end
            wait_nxt  = q_data.wait_ms;
            step_nxt  = '0;
            state_nxt = ST_FADE;
          end else if (q_data.kind < lpcs_pkg::KIND_FADE) begin
            if (can_emit) begin
              q_pop   = 1'b1;
              vld_nxt = 1'b1;
              cur_nxt = cur_eff;
              res_nxt = '0;
              res_nxt.last = 1'b1;
              unique case (q_data.kind)
                lpcs_pkg::KIND_SET_PIXEL: begin
                  res_nxt.action      = lpcs_pkg::ACT_SET_PIXEL;
                  res_nxt.pixel_index = q_data.arg_a;
                  res_nxt.red         = q_data.arg_b;
                  res_nxt.green       = q_data.arg_c;
                  res_nxt.blue        = q_data.arg_param[7:0];
                end
                lpcs_pkg::KIND_FILL: begin
                  cur_nxt        = {q_data.arg_c, q_data.arg_b, q_data.arg_a[7:0]};
                  res_nxt.action = lpcs_pkg::ACT_FILL;
                  res_nxt.red    = q_data.arg_a[7:0];
                  res_nxt.green  = q_data.arg_b;
                  res_nxt.blue   = q_data.arg_c;
                end
                lpcs_pkg::KIND_SHOW: begin
                  res_nxt.action = lpcs_pkg::ACT_SHOW;
                end
                lpcs_pkg::KIND_DELAY: begin
                  res_nxt.action   = lpcs_pkg::ACT_DELAY;
                  res_nxt.delay_ms = q_data.arg_param;
                end
                default: begin
                  res_nxt.action = lpcs_pkg::ACT_SHOW;
                end
              endcase
            end
          end else begin
            // unknown kind: only the color clear takes effect
            q_pop   = 1'b1;
            cur_nxt = cur_eff;
          end
        end
      end
      ST_FADE: begin
        if (can_emit) begin
          vld_nxt             = 1'b1;
          res_nxt.action      = lpcs_pkg::ACT_FADE_FRAME;
          res_nxt.pixel_index = '0;
          res_nxt.red         = frame_col[0];
          res_nxt.green       = frame_col[1];
          res_nxt.blue        = frame_col[2];
          res_nxt.delay_ms    = 16'(wait_r);
          res_nxt.last        = last_frame;
          qa_nxt              = qv;
          rem_nxt             = rem_new;
          step_nxt            = step_r + 1'b1;
          if (last_frame) begin
            cur_nxt   = tgt_r;
            step_nxt  = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      cur_r   <= '0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      cur_r   <= cur_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r  <= tgt_nxt;
    dq_r   <= dq_nxt;
    dr_r   <= dr_nxt;
    qa_r   <= qa_nxt;
    rem_r  <= rem_nxt;
    neg_r  <= neg_nxt;
    wait_r <= wait_nxt;
    res_r  <= res_nxt;
  end

  assign empty       = !vld_r;
  assign res         = res_r;
  assign stat.fading = (state_r == ST_FADE);
  assign stat.step   = step_r;

endmodule

[hw/rtl/led_pattern_command_sequencer_unit.sv]
// LED pattern command sequencer, top level: front end, command queue, back end.
// Depends on lpcs_pkg, lpcs_front, lpcs_cmdq, lpcs_back.
//
// Set pixel, fill, show and delay commands each give one result; a fade gives
// fifty frame results, one per cycle while pop keeps up, after a setup in the
// idle state, and holds the back-end sequencer in the fade state for them.
// Commands are held in a CMDQ_DEPTH-entry queue, so push keeps being taken
// during a fade until that queue fills. A result reaches the out_ ports via
// the command queue and the back end's result register, the first frame of a
// fade also via the fade setup registers; the single result register sets the
// rate of one result per cycle while pop keeps up.
module led_pattern_command_sequencer_unit #(
  parameter int CMDQ_DEPTH = lpcs_pkg::CMDQ_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_kind,
  input  logic        in_first_step,
  input  logic [15:0] in_arg_a,
  input  logic [7:0]  in_arg_b,
  input  logic [7:0]  in_arg_c,
  input  logic [15:0] in_arg_param,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_action,
  output logic [15:0] out_pixel_index,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [15:0] out_delay_ms,
  output logic        out_last
);

  lpcs_pkg::cmd_t     q_wdata, q_rdata;
  lpcs_pkg::res_t     res;
  lpcs_pkg::bk_stat_t stat;
  logic               q_wr, q_full, q_pop, q_empty;

  assign full = q_full;

  lpcs_front u_front (
    .in_push_ok    (push && !q_full),
    .in_kind       (in_kind),
    .in_first_step (in_first_step),
    .in_arg_a      (in_arg_a),
    .in_arg_b      (in_arg_b),
    .in_arg_c      (in_arg_c),
    .in_arg_param  (in_arg_param),
    .q_wr          (q_wr),
    .q_wdata       (q_wdata)
  );

  lpcs_cmdq #(
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  lpcs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .res     (res),
    .stat    (stat)
  );

  assign out_action      = res.action;
  assign out_pixel_index = res.pixel_index;
  assign out_red         = res.red;
  assign out_green       = res.green;
  assign out_blue        = res.blue;
  assign out_delay_ms    = res.delay_ms;
  assign out_last        = res.last;

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    stat.fading |-> (stat.step < 6'(lpcs_pkg::FADE_FRAMES)))
    else $error("fade step out of range");

  a_fade_starts_clean: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(stat.fading) |-> (stat.step == '0))
    else $error("fade started with nonzero step");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_action != lpcs_pkg::ACT_FADE_FRAME)) |-> out_last)
    else $error("single-result action without last");

  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command popped from empty queue");

endmodule

[tb/lpcs_cmd_checker.sv]
`timescale 1ns / 100ps
// Result checker for the LED pattern command sequencer: predicts the action
// items of every accepted command and compares them with popped results.
// Depends on lpcs_pkg for the command kinds, action codes and result struct.
module lpcs_cmd_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic [2:0]  in_kind,
  input  logic        in_first_step,
  input  logic [15:0] in_arg_a,
  input  logic [7:0]  in_arg_b,
  input  logic [7:0]  in_arg_c,
  input  logic [15:0] in_arg_param,
  input  logic        empty,
  input  logic        pop,
  input  logic [2:0]  out_action,
  input  logic [15:0] out_pixel_index,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic [15:0] out_delay_ms,
  input  logic        out_last,
  output int          mismatches,
  output int          actions_pending
);
  import lpcs_pkg::*;

  localparam int FADE_TOTAL_MS [5] = '{100, 200, 300, 400, 500};

  res_t       expected_actions [$];
  logic [7:0] color_r, color_g, color_b;

  initial begin
    mismatches = 0;
    actions_pending = 0;
    color_r = '0;
    color_g = '0;
    color_b = '0;
  end

  function automatic logic [7:0] fade_level(logic [7:0] cur, logic [7:0] tgt, int s);
    int delta;
    delta = int'(tgt) - int'(cur);
    return 8'(int'(cur) + (delta * s) / FADE_FRAMES);
  endfunction

  function automatic res_t make_action(logic [2:0] act, logic [15:0] idx, logic [7:0] r,
                                       logic [7:0] g, logic [7:0] b, logic [15:0] dly,
                                       logic lst);
    res_t x;
    x.action      = act;
    x.pixel_index = idx;
    x.red         = r;
    x.green       = g;
    x.blue        = b;
    x.delay_ms    = dly;
    x.last        = lst;
    return x;
  endfunction

  task automatic predict_actions(logic [2:0] kind, logic fs, logic [15:0] a,
                                 logic [7:0] b, logic [7:0] c, logic [15:0] p);
    logic [15:0] frame_wait;
    if (fs) begin
      color_r = '0;
      color_g = '0;
      color_b = '0;
    end
    case (kind)
      KIND_SET_PIXEL: begin
        expected_actions.push_back(make_action(ACT_SET_PIXEL, a, b, c, p[7:0], '0, 1'b1));
      end
      KIND_FILL: begin
        color_r = a[7:0];
        color_g = b;
        color_b = c;
        expected_actions.push_back(make_action(ACT_FILL, '0, color_r, color_g, color_b,
                                               '0, 1'b1));
      end
      KIND_SHOW: begin
        expected_actions.push_back(make_action(ACT_SHOW, '0, '0, '0, '0, '0, 1'b1));
      end
      KIND_DELAY: begin
        expected_actions.push_back(make_action(ACT_DELAY, '0, '0, '0, '0, p, 1'b1));
      end
      KIND_FADE: begin
        frame_wait = 16'(FADE_TOTAL_MS[a % 5] / FADE_FRAMES);
        for (int s = 1; s <= FADE_FRAMES; s++) begin
          expected_actions.push_back(make_action(ACT_FADE_FRAME, '0,
                                                 fade_level(color_r, b, s),
                                                 fade_level(color_g, c, s),
                                                 fade_level(color_b, p[7:0], s),
                                                 frame_wait, s == FADE_FRAMES));
        end
        color_r = b;
        color_g = c;
        color_b = p[7:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic compare_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      expected_actions.delete();
      color_r = '0;
      color_g = '0;
      color_b = '0;
    end else begin
      if (pop && !empty) begin
        if (expected_actions.size() == 0) begin
          $display("%0t: unexpected item: expected none, actual action %0h", $time,
                   out_action);
          mismatches++;
        end else begin
          want = expected_actions.pop_front();
          compare_field("action", want.action, out_action);
          compare_field("pixel_index", want.pixel_index, out_pixel_index);
          compare_field("red", want.red, out_red);
          compare_field("green", want.green, out_green);
          compare_field("blue", want.blue, out_blue);
          compare_field("delay_ms", want.delay_ms, out_delay_ms);
          compare_field("last", want.last, out_last);
        end
      end
      if (push && !full) begin
        predict_actions(in_kind, in_first_step, in_arg_a, in_arg_b, in_arg_c, in_arg_param);
      end
    end
    actions_pending = expected_actions.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Testbench top for led_pattern_command_sequencer_unit: drives directed and
// random commands with bursty push and stalling pop; lpcs_cmd_checker checks.
module tb;
  import lpcs_pkg::*;

  localparam logic [2:0] KIND_RSVD_LO = 3'd5;
  localparam logic [2:0] KIND_RSVD_HI = 3'd7;
  localparam int RANDOM_ITEMS = 100;
  localparam int IDLE_LIMIT   = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  in_kind = '0;
  logic        in_first_step = 1'b0;
  logic [15:0] in_arg_a = '0;
  logic [7:0]  in_arg_b = '0;
  logic [7:0]  in_arg_c = '0;
  logic [15:0] in_arg_param = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  out_action;
  logic [15:0] out_pixel_index;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [15:0] out_delay_ms;
  logic        out_last;
  int          mismatches;
  int          actions_pending;
  int          idle_cycles = 0;
  int          burst_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  led_pattern_command_sequencer_unit DUT (
    .clk, .rst_n, .push, .full, .in_kind, .in_first_step, .in_arg_a, .in_arg_b,
    .in_arg_c, .in_arg_param, .empty, .pop, .out_action, .out_pixel_index, .out_red,
    .out_green, .out_blue, .out_delay_ms, .out_last
  );

  lpcs_cmd_checker u_checker (
    .clk, .rst_n, .push, .full, .in_kind, .in_first_step, .in_arg_a, .in_arg_b,
    .in_arg_c, .in_arg_param, .empty, .pop, .out_action, .out_pixel_index, .out_red,
    .out_green, .out_blue, .out_delay_ms, .out_last, .mismatches, .actions_pending
  );

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // receiver: pop rate changes in runs
  initial begin
    int mode;
    int run_len;
    forever begin
      mode = $urandom_range(0, 3);
      run_len = $urandom_range(10, 150);
      repeat (run_len) begin
        @(negedge clk);
        case (mode)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          2: pop <= ($urandom_range(0, 3) == 0);
          default: pop <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic send_cmd(logic [2:0] kind, logic fs, logic [15:0] a, logic [7:0] b,
                          logic [7:0] c, logic [15:0] p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    push          <= 1'b1;
    in_kind       <= kind;
    in_first_step <= fs;
    in_arg_a      <= a;
    in_arg_b      <= b;
    in_arg_c      <= c;
    in_arg_param  <= p;
    do @(posedge clk); while (full);
  endtask

  task automatic drain_results();
    @(negedge clk);
    push <= 1'b0;
    while (actions_pending != 0) @(negedge clk);
  endtask

  initial begin
    int sent;
    int pick;
    logic [2:0] kind;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_cmd(KIND_SET_PIXEL, 1'b0, 16'h0000, 8'h00, 8'h00, 16'h0000);
    send_cmd(KIND_SET_PIXEL, 1'b0, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF);
    send_cmd(KIND_SET_PIXEL, 1'b0, 16'd64, 8'h12, 8'h34, 16'hAB56);
    send_cmd(KIND_FILL, 1'b0, 16'hFFFF, 8'hFF, 8'hFF, 16'h0000);
    send_cmd(KIND_SHOW, 1'b0, 16'h1234, 8'h56, 8'h78, 16'h9ABC);
    send_cmd(KIND_DELAY, 1'b0, 16'h0000, 8'h00, 8'h00, 16'h0000);
    send_cmd(KIND_DELAY, 1'b0, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF);
    send_cmd(KIND_FADE, 1'b0, 16'd0, 8'h00, 8'h00, 16'hFF00);
    send_cmd(KIND_FADE, 1'b0, 16'd1, 8'hFF, 8'hFF, 16'h00FF);
    send_cmd(KIND_FADE, 1'b0, 16'd2, 8'h07, 8'hC8, 16'h1234);
    send_cmd(KIND_FADE, 1'b1, 16'd3, 8'h80, 8'h40, 16'h0020);
    send_cmd(KIND_FADE, 1'b0, 16'd4, 8'h03, 8'hF1, 16'hFF9C);
    send_cmd(KIND_FADE, 1'b0, 16'hFFFF, 8'h31, 8'h00, 16'h00FE);
    send_cmd(KIND_FILL, 1'b1, 16'h1200, 8'h99, 8'h01, 16'h0000);
    send_cmd(KIND_FILL, 1'b0, 16'h0055, 8'hAA, 8'h5A, 16'h0000);
    send_cmd(KIND_RSVD_LO, 1'b1, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF);
    send_cmd(KIND_FADE, 1'b0, 16'd5, 8'h10, 8'h20, 16'h0030);
    send_cmd(KIND_RSVD_HI, 1'b0, 16'h0000, 8'h00, 8'h00, 16'h0000);
    send_cmd(KIND_SHOW, 1'b1, 16'h0000, 8'h00, 8'h00, 16'h0000);
    send_cmd(KIND_FADE, 1'b0, 16'd9, 8'hFF, 8'h00, 16'h0080);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 15);
      if (pick < 2) begin
        kind = KIND_FADE;
      end else if (pick < 4) begin
        kind = 3'($urandom_range(KIND_RSVD_LO, KIND_RSVD_HI));
      end else begin
        kind = 3'($urandom_range(KIND_SET_PIXEL, KIND_DELAY));
      end
      if (sent == RANDOM_ITEMS / 2) begin
        drain_results();
      end
      send_cmd(kind, $urandom_range(0, 3) == 0, 16'($urandom), 8'($urandom), 8'($urandom),
               16'($urandom));
      sent++;
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
